[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the RTL file that checks its own logic.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define AST_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Antecedent implies consequent at the next clock edge.
`define AST_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/hawf_pkg.sv]
// ----------------------------------------------------------------------------
// hawf_pkg
// Types, constants and the arctangent table of the hit angle window filter.
// ----------------------------------------------------------------------------
`default_nettype none

package hawf_pkg;

  localparam int COORD_BITS      = 16;
  localparam int ANGLE_FRAC_BITS = 6;
  localparam int MIN_HITS        = 4;

  // coordinates wider than 24 bits are floored down to 24 bits
  localparam int PRE_SHIFT  = (COORD_BITS > 24) ? COORD_BITS - 24 : 0;
  localparam int CW         = COORD_BITS - PRE_SHIFT;
  localparam int PW         = 2 * CW + 2;
  localparam int MW         = (2 * CW > 29) ? 2 * CW : 29;
  localparam int NORM_STEPS = $clog2(MW);
  localparam int UW         = 29;
  localparam int SQ_W       = 61;
  localparam int SQRT_STEPS = 30;
  localparam int ZBITS      = 20;
  localparam int CORDIC_STEPS = 20;
  localparam int XW         = 34;
  localparam int ZW         = 32;
  localparam int ANGLE_W    = 14;
  localparam int REG_W      = 14;
  localparam int CFG_IDX_W  = 4;
  localparam int HIT_W      = 4;
  localparam int ANGLE_MAX  = 16383;
  localparam int THETA_MEAN_RST = 5760;
  localparam int ANGLE_TOP  = ((180 << ANGLE_FRAC_BITS) > ANGLE_MAX) ?
                              ANGLE_MAX : (180 << ANGLE_FRAC_BITS);
  // pipeline depth of one angle unit
  localparam int ANGLE_LAT  = 4 + NORM_STEPS + 2 + SQRT_STEPS + 1 + CORDIC_STEPS + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THETA_MEAN  = 4'd0,
    REG_THETA_WIDTH = 4'd1
  } hawf_reg_t;

  typedef struct packed {
    logic [HIT_W-1:0]             hit_count;
    logic signed [COORD_BITS-1:0] first_x;
    logic signed [COORD_BITS-1:0] first_y;
    logic signed [COORD_BITS-1:0] first_z;
    logic signed [COORD_BITS-1:0] second_x;
    logic signed [COORD_BITS-1:0] second_y;
    logic signed [COORD_BITS-1:0] second_z;
    logic signed [COORD_BITS-1:0] fourth_x;
    logic signed [COORD_BITS-1:0] fourth_y;
    logic signed [COORD_BITS-1:0] fourth_z;
  } hawf_in_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle_four_one;
    logic [ANGLE_W-1:0] angle_four_two;
    logic               angles_valid;
    logic               in_window;
    logic               reject;
  } hawf_out_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } hawf_vec_t;

  typedef struct packed {
    logic      hits_ok;
    logic      zero_41;
    logic      zero_42;
    hawf_vec_t h1;
    hawf_vec_t h2;
    hawf_vec_t h4;
  } hawf_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } hawf_q_stat_t;

  // atan(2^-i) in units of 2^-20 degree
  function automatic logic signed [ZW-1:0] hawf_atan(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:    v = 32'sd47185920;
      5'd1:    v = 32'sd27855475;
      5'd2:    v = 32'sd14718068;
      5'd3:    v = 32'sd7471121;
      5'd4:    v = 32'sd3750058;
      5'd5:    v = 32'sd1876857;
      5'd6:    v = 32'sd938658;
      5'd7:    v = 32'sd469357;
      5'd8:    v = 32'sd234682;
      5'd9:    v = 32'sd117342;
      5'd10:   v = 32'sd58671;
      5'd11:   v = 32'sd29335;
      5'd12:   v = 32'sd14668;
      5'd13:   v = 32'sd7334;
      5'd14:   v = 32'sd3667;
      5'd15:   v = 32'sd1833;
      5'd16:   v = 32'sd917;
      5'd17:   v = 32'sd458;
      5'd18:   v = 32'sd229;
      5'd19:   v = 32'sd115;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[rtl/hawf_front.sv]
// ----------------------------------------------------------------------------
// hawf_front
// Classifies an incoming event: hit count check, coordinate scaling and
// zero-length vector flags, packed into one job for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module hawf_front (
  input  hawf_pkg::hawf_in_t  in_data,
  output hawf_pkg::hawf_job_t job
);

  function automatic hawf_pkg::hawf_vec_t scale_vec(
    input logic signed [hawf_pkg::COORD_BITS-1:0] x,
    input logic signed [hawf_pkg::COORD_BITS-1:0] y,
    input logic signed [hawf_pkg::COORD_BITS-1:0] z
  );
    hawf_pkg::hawf_vec_t v;
    v.x = hawf_pkg::CW'(x >>> hawf_pkg::PRE_SHIFT);
    v.y = hawf_pkg::CW'(y >>> hawf_pkg::PRE_SHIFT);
    v.z = hawf_pkg::CW'(z >>> hawf_pkg::PRE_SHIFT);
    return v;
  endfunction

  hawf_pkg::hawf_vec_t h1, h2, h4;
  logic                z1, z2, z4;

  assign h1 = scale_vec(in_data.first_x, in_data.first_y, in_data.first_z);
  assign h2 = scale_vec(in_data.second_x, in_data.second_y, in_data.second_z);
  assign h4 = scale_vec(in_data.fourth_x, in_data.fourth_y, in_data.fourth_z);

  assign z1 = (h1 == '0);
  assign z2 = (h2 == '0);
  assign z4 = (h4 == '0);

  always_comb begin
    job.hits_ok = (in_data.hit_count >= hawf_pkg::HIT_W'(hawf_pkg::MIN_HITS));
    job.zero_41 = z4 | z1;
    job.zero_42 = z4 | z2;
    job.h1      = h1;
    job.h2      = h2;
    job.h4      = h4;
  end

endmodule

`default_nettype wire

[rtl/hawf_queue.sv]
// ----------------------------------------------------------------------------
// hawf_queue
// Small job queue between the classifying front and the angle back end.
// ----------------------------------------------------------------------------
`default_nettype none

module hawf_queue #(
  parameter int DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  hawf_pkg::hawf_job_t    push_data,
  input  logic                   pop,
  output hawf_pkg::hawf_job_t    head_data,
  output hawf_pkg::hawf_q_stat_t stat
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  hawf_pkg::hawf_job_t mem_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                do_push, do_pop;

  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

[rtl/hawf_angle.sv]
// ----------------------------------------------------------------------------
// hawf_angle
// Pipelined angle between two vectors: products, normalization, square
// root of the cross product length, then a CORDIC arctangent.
// ----------------------------------------------------------------------------
`default_nettype none

module hawf_angle (
  input  logic                             clk,
  input  logic                             en,
  input  hawf_pkg::hawf_vec_t              a,
  input  hawf_pkg::hawf_vec_t              b,
  output logic [hawf_pkg::ANGLE_W-1:0]     angle
);

  localparam int CW  = hawf_pkg::CW;
  localparam int PW  = hawf_pkg::PW;
  localparam int MW  = hawf_pkg::MW;
  localparam int NS  = hawf_pkg::NORM_STEPS;
  localparam int UW  = hawf_pkg::UW;
  localparam int SQW = hawf_pkg::SQ_W;
  localparam int SQS = hawf_pkg::SQRT_STEPS;
  localparam int CS  = hawf_pkg::CORDIC_STEPS;
  localparam int XW  = hawf_pkg::XW;
  localparam int ZW  = hawf_pkg::ZW;
  localparam int RSH = hawf_pkg::ZBITS - hawf_pkg::ANGLE_FRAC_BITS;
  localparam logic signed [ZW-1:0] Z_90   = ZW'(90 * (1 << hawf_pkg::ZBITS));
  localparam logic signed [ZW-1:0] Z_180  = ZW'(180 * (1 << hawf_pkg::ZBITS));
  localparam logic signed [ZW-1:0] Z_HALF = ZW'(1 << (RSH - 1));

  function automatic logic [MW-1:0] mag_of(input logic signed [PW-1:0] v);
    logic [PW-1:0] u;
    u = (v < 0) ? PW'(-v) : PW'(v);
    return MW'(u);
  endfunction

  // products
  logic signed [2*CW-1:0] p_r [9];
  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= a.x * b.x;
      p_r[1] <= a.y * b.y;
      p_r[2] <= a.z * b.z;
      p_r[3] <= a.y * b.z;
      p_r[4] <= a.z * b.y;
      p_r[5] <= a.z * b.x;
      p_r[6] <= a.x * b.z;
      p_r[7] <= a.x * b.y;
      p_r[8] <= a.y * b.x;
    end
  end

  // dot and cross sums
  logic signed [PW-1:0] d_r;
  logic signed [PW-1:0] c_r [3];
  always_ff @(posedge clk) begin
    if (en) begin
      d_r    <= PW'(p_r[0]) + PW'(p_r[1]) + PW'(p_r[2]);
      c_r[0] <= PW'(p_r[3]) - PW'(p_r[4]);
      c_r[1] <= PW'(p_r[5]) - PW'(p_r[6]);
      c_r[2] <= PW'(p_r[7]) - PW'(p_r[8]);
    end
  end

  // magnitudes, index 0 is the dot product
  logic [MW-1:0] mag_r [4];
  logic          dneg_m_r;
  always_ff @(posedge clk) begin
    if (en) begin
      mag_r[0] <= mag_of(d_r);
      mag_r[1] <= mag_of(c_r[0]);
      mag_r[2] <= mag_of(c_r[1]);
      mag_r[3] <= mag_of(c_r[2]);
      dneg_m_r <= (d_r < 0);
    end
  end

  // maximum, then left normalization; entry 4 carries the maximum
  logic [MW-1:0] nm_r   [NS+1][5];
  logic          dneg_n_r [NS+1];
  logic [MW-1:0] max01, max23;
  assign max01 = (mag_r[0] > mag_r[1]) ? mag_r[0] : mag_r[1];
  assign max23 = (mag_r[2] > mag_r[3]) ? mag_r[2] : mag_r[3];

  always_ff @(posedge clk) begin
    if (en) begin
      nm_r[0][0]  <= mag_r[0];
      nm_r[0][1]  <= mag_r[1];
      nm_r[0][2]  <= mag_r[2];
      nm_r[0][3]  <= mag_r[3];
      nm_r[0][4]  <= (max01 > max23) ? max01 : max23;
      dneg_n_r[0] <= dneg_m_r;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_norm
    localparam int SH = 1 << (NS - 1 - k);
    logic do_shift;
    assign do_shift = (nm_r[k][4][MW-1 -: SH] == '0);
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 5; i++) begin
          nm_r[k+1][i] <= do_shift ? (nm_r[k][i] << SH) : nm_r[k][i];
        end
        dneg_n_r[k+1] <= dneg_n_r[k];
      end
    end
  end

  // squares of the scaled cross components
  logic [2*UW-1:0] sq_r [3];
  logic [UW-1:0]   ud_q_r;
  logic            dneg_q_r;
  always_ff @(posedge clk) begin
    if (en) begin
      sq_r[0]  <= nm_r[NS][1][MW-1 -: UW] * nm_r[NS][1][MW-1 -: UW];
      sq_r[1]  <= nm_r[NS][2][MW-1 -: UW] * nm_r[NS][2][MW-1 -: UW];
      sq_r[2]  <= nm_r[NS][3][MW-1 -: UW] * nm_r[NS][3][MW-1 -: UW];
      ud_q_r   <= nm_r[NS][0][MW-1 -: UW];
      dneg_q_r <= dneg_n_r[NS];
    end
  end

  // integer square root, one result bit a stage
  logic [SQW-1:0] sv_r   [SQS+1];
  logic [SQW-1:0] sres_r [SQS+1];
  logic [UW-1:0]  sud_r  [SQS+1];
  logic           sdn_r  [SQS+1];
  always_ff @(posedge clk) begin
    if (en) begin
      sv_r[0]   <= SQW'(sq_r[0]) + SQW'(sq_r[1]) + SQW'(sq_r[2]);
      sres_r[0] <= '0;
      sud_r[0]  <= ud_q_r;
      sdn_r[0]  <= dneg_q_r;
    end
  end

  for (genvar k = 0; k < SQS; k++) begin : g_sqrt
    localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (SQS - 1 - k));
    logic [SQW-1:0] trial;
    assign trial = sres_r[k] + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (sv_r[k] >= trial) begin
          sv_r[k+1]   <= sv_r[k] - trial;
          sres_r[k+1] <= (sres_r[k] >> 1) + BIT;
        end else begin
          sv_r[k+1]   <= sv_r[k];
          sres_r[k+1] <= sres_r[k] >> 1;
        end
        sud_r[k+1] <= sud_r[k];
        sdn_r[k+1] <= sdn_r[k];
      end
    end
  end

  // CORDIC vectoring; an obtuse angle starts rotated by 90 degrees
  logic signed [XW-1:0] cx_r [CS+1];
  logic signed [XW-1:0] cy_r [CS+1];
  logic signed [ZW-1:0] cz_r [CS+1];
  always_ff @(posedge clk) begin
    if (en) begin
      if (sdn_r[SQS]) begin
        cx_r[0] <= XW'(sres_r[SQS]);
        cy_r[0] <= XW'(sud_r[SQS]);
        cz_r[0] <= Z_90;
      end else begin
        cx_r[0] <= XW'(sud_r[SQS]);
        cy_r[0] <= XW'(sres_r[SQS]);
        cz_r[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < CS; i++) begin : g_cordic
    logic signed [XW-1:0] dx, dy;
    assign dx = cx_r[i] >>> i;
    assign dy = cy_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        if (cy_r[i] > 0) begin
          cx_r[i+1] <= cx_r[i] + dy;
          cy_r[i+1] <= cy_r[i] - dx;
          cz_r[i+1] <= cz_r[i] + hawf_pkg::hawf_atan(5'(i));
        end else begin
          cx_r[i+1] <= cx_r[i] - dy;
          cy_r[i+1] <= cy_r[i] + dx;
          cz_r[i+1] <= cz_r[i] - hawf_pkg::hawf_atan(5'(i));
        end
      end
    end
  end

  // clamp to [0, 180] degrees, round half up, saturate
  logic signed [ZW-1:0]          zc, zt;
  logic [hawf_pkg::ANGLE_W-1:0]  angle_r, angle_nxt;
  always_comb begin
    if (cz_r[CS] < 0) begin
      zc = '0;
    end else if (cz_r[CS] > Z_180) begin
      zc = Z_180;
    end else begin
      zc = cz_r[CS];
    end
    zt = (zc + Z_HALF) >>> RSH;
    angle_nxt = (zt > ZW'(hawf_pkg::ANGLE_MAX)) ? hawf_pkg::ANGLE_W'(hawf_pkg::ANGLE_MAX)
                                                  : hawf_pkg::ANGLE_W'(zt);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_r <= angle_nxt;
    end
  end

  assign angle = angle_r;

endmodule

`default_nettype wire

[rtl/hawf_back.sv]
// ----------------------------------------------------------------------------
// hawf_back
// Back end: pops jobs, runs both angle pipelines, applies the window test
// and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hawf_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  hawf_pkg::hawf_job_t          q_data,
  input  logic                         q_empty,
  output logic                         q_pop,
  input  logic [hawf_pkg::REG_W-1:0]   theta_mean,
  input  logic [hawf_pkg::REG_W-1:0]   theta_width,
  output logic                         out_valid,
  input  logic                         out_stall,
  output hawf_pkg::hawf_out_t          out_data
);

  localparam int LAT = hawf_pkg::ANGLE_LAT;
  localparam int AW  = hawf_pkg::ANGLE_W;
  localparam int RW  = hawf_pkg::REG_W;

  function automatic logic in_range(input logic [AW-1:0] ang,
                                    input logic [RW-1:0] mean,
                                    input logic [RW-1:0] width);
    logic signed [AW:0] diff;
    logic [AW:0]        mag;
    diff = $signed({1'b0, ang}) - $signed({1'b0, mean});
    mag  = (diff < 0) ? (AW+1)'(-diff) : (AW+1)'(diff);
    return mag < {1'b0, width};
  endfunction

  logic                en;
  logic [LAT-1:0]      vld_r;
  logic [LAT-1:0]      hok_r;
  logic [LAT-1:0]      z41_r;
  logic [LAT-1:0]      z42_r;
  logic [AW-1:0]       ang41, ang42, a41, a42;
  logic                w41, w42, hok;
  logic                out_valid_r;
  hawf_pkg::hawf_out_t out_data_r, out_data_nxt;

  // advance the whole back end unless a finished result is held
  assign en    = !out_valid_r || !out_stall;
  assign q_pop = en && !q_empty;

  hawf_angle u_angle_41 (
    .clk   (clk),
    .en    (en),
    .a     (q_data.h4),
    .b     (q_data.h1),
    .angle (ang41)
  );

  hawf_angle u_angle_42 (
    .clk   (clk),
    .en    (en),
    .a     (q_data.h4),
    .b     (q_data.h2),
    .angle (ang42)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], !q_empty};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hok_r <= {hok_r[LAT-2:0], q_data.hits_ok};
      z41_r <= {z41_r[LAT-2:0], q_data.zero_41};
      z42_r <= {z42_r[LAT-2:0], q_data.zero_42};
    end
  end

  assign hok = hok_r[LAT-1];
  assign a41 = z41_r[LAT-1] ? '0 : ang41;
  assign a42 = z42_r[LAT-1] ? '0 : ang42;
  assign w41 = in_range(a41, theta_mean, theta_width);
  assign w42 = in_range(a42, theta_mean, theta_width);

  always_comb begin
    out_data_nxt.angle_four_one = hok ? a41 : '0;
    out_data_nxt.angle_four_two = hok ? a42 : '0;
    out_data_nxt.angles_valid   = hok;
    out_data_nxt.in_window      = hok && w41 && w42;
    out_data_nxt.reject         = hok && !(w41 && w42);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[rtl/hit_angle_window_filter.sv]
// ----------------------------------------------------------------------------
// hit_angle_window_filter
// Angle window filter on three hit positions of a detector event.
// ----------------------------------------------------------------------------
// Takes one event per clock while the queue is not full and returns one result
// per event in order. Each event passes a QUEUE_DEPTH-entry queue into two
// fully pipelined angle units (products, normalization, 30-stage square root,
// 20-stage CORDIC) and then the output register, and a new event is taken
// every cycle unless the full queue raises in_stall.
// A stall on the output freezes the angle pipelines; the queue takes events
// until it is full. Window registers should be written while no event is in
// flight; a write is taken in the cycle it is offered.
`default_nettype none

`include "assert_macros.svh"

module hit_angle_window_filter #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  hawf_pkg::hawf_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output hawf_pkg::hawf_out_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hawf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hawf_pkg::REG_W-1:0]          cfg_data
);

  hawf_pkg::hawf_job_t    job, head;
  hawf_pkg::hawf_q_stat_t q_stat;
  logic                   q_pop;
  logic [hawf_pkg::REG_W-1:0] theta_mean_r, theta_width_r;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_stat.full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      theta_mean_r  <= hawf_pkg::REG_W'(hawf_pkg::THETA_MEAN_RST);
      theta_width_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hawf_pkg::REG_THETA_MEAN:  theta_mean_r  <= cfg_data;
        hawf_pkg::REG_THETA_WIDTH: theta_width_r <= cfg_data;
        default: ;
      endcase
    end
  end

  hawf_front u_front (
    .in_data (in_data),
    .job     (job)
  );

  hawf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_data (job),
    .pop       (q_pop),
    .head_data (head),
    .stat      (q_stat)
  );

  hawf_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_data      (head),
    .q_empty     (q_stat.empty),
    .q_pop       (q_pop),
    .theta_mean  (theta_mean_r),
    .theta_width (theta_width_r),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  `AST_ALWAYS(a_reject_needs_valid, clk, rst_n,
    !out_valid || !out_data.reject || out_data.angles_valid)
  `AST_ALWAYS(a_reject_is_not_window, clk, rst_n,
    !out_valid || (out_data.reject == (out_data.angles_valid && !out_data.in_window)))
  `AST_ALWAYS(a_angle_range, clk, rst_n,
    !out_valid || (out_data.angle_four_one <= hawf_pkg::ANGLE_W'(hawf_pkg::ANGLE_TOP)))
  `AST_NEXT(a_full_needs_transfer, clk, rst_n,
    !in_stall && !(in_valid && !in_stall), !in_stall)

endmodule

`default_nettype wire
